// ===== hdl/assert_macros.svh =====
// Assertion helpers for the lateral and heading error block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PLHE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PLHE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/plhe_pkg.sv =====
package plhe_pkg;

	// Odd Taylor terms of sin(pi*z/2), Q30
	localparam logic [30:0] SIN_C1 = 31'd1686629713;
	localparam logic [30:0] SIN_C3 = 31'd693598668;
	localparam logic [30:0] SIN_C5 = 31'd85569306;
	localparam logic [30:0] SIN_C7 = 31'd5026995;
	localparam logic [30:0] SIN_C9 = 31'd172272;

	// Horner steps after the leading term, innermost first
	localparam int NCELL = 4;
	localparam logic [NCELL-1:0][30:0] HORNER_COEF = {SIN_C1, SIN_C3, SIN_C5, SIN_C7};

	localparam int HEAD_SCALE = 46080;      // 1/128 degree per half turn * 2
	localparam int HEAD_LIM   = 23040;
	localparam int Q15_HALF   = 16384;
	localparam logic [31:0] LAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] LAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [15:0] hc;
	} side_t;

	typedef struct packed {
		logic [30:0] z;
		logic [30:0] z2;
		logic [30:0] t;
		logic        neg;
	} lane_t;

	typedef struct packed {
		lane_t sn;
		lane_t cs;
		side_t side;
	} poly_t;

	// Q30 product, truncated
	function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = 62'(a) * 62'(b);
		return p[60:30];
	endfunction

	// Round a Q30 magnitude to Q15, cap and apply the sign
	function automatic logic signed [15:0] q15_of(input logic [30:0] s, input logic neg);
		logic [31:0] r;
		logic [16:0] m;
		logic [15:0] c;
		r = 32'(s) + 32'(Q15_HALF);
		m = r[31:15];
		c = (m > 17'd32767) ? 16'd32767 : m[15:0];
		return neg ? -$signed(c) : $signed(c);
	endfunction

endpackage

// ===== hdl/plhe_pose_if.sv =====
interface plhe_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic        [15:0] start_heading;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic        [15:0] end_heading;

	modport source (
		output valid, start_x, start_y, start_heading, end_x, end_y, end_heading,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, start_heading, end_x, end_y, end_heading,
		output ready
	);
endinterface

// ===== hdl/plhe_track_if.sv =====
interface plhe_track_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] lateral_offset;
	logic signed [15:0] heading_change_deg;
	logic               saturated;

	modport source (
		output valid, lateral_offset, heading_change_deg, saturated,
		input  ready
	);
	modport sink (
		input  valid, lateral_offset, heading_change_deg, saturated,
		output ready
	);
endinterface

// ===== hdl/pose_lateral_and_heading_error_top.sv =====
// Lateral offset and heading change of a pose pair.
// Channel pose (sink): start and end pose, x and y in signed Q21.10 metres,
// headings as binary angles. Channel track (source): lateral_offset in
// Q21.10 metres (dy*sin(h0) - dx*cos(h0), clamped to 32 bits, saturated set
// when clamped) and heading_change_deg, the negated wrapped heading change in
// 1/128 degree. Every transfer on pose yields exactly one transfer on track,
// in order.
// Path: every pose transfer passes through the 16-register pipeline: phase
// reconstruction, quadrant fold, the row of Horner cells that evaluates sine
// and cosine side by side, rounding, the two lateral products and the final
// clamp.
// Throughput: one pose pair per cycle while track takes results; every stage holds one item.
// Stall: each stage moves on when its successor is empty or moving, so a
// result held on track does not block pose while bubbles remain upstream;
// only a full pipeline drops pose.ready.
// Reset: arst_n empties every stage at once; no table or memory needs a
// clearing pass, so pose.ready is high from the first cycle after reset.
`include "assert_macros.svh"

module pose_lateral_and_heading_error_top import plhe_pkg::*; #(
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input logic          clk,
	input logic          arst_n,
	plhe_pose_if.sink    pose,
	plhe_track_if.source track
);

	localparam int AB  = ANGLE_BITS;
	localparam int IW  = $clog2(SINE_TABLE_DEPTH);  // table index width
	localparam int KW  = 2 * IW;                     // width of the index remainder product
	localparam longint unsigned PH_Q  = (64'd1 << 32) / SINE_TABLE_DEPTH;
	localparam longint unsigned PH_R  = (64'd1 << 32) % SINE_TABLE_DEPTH;
	localparam longint unsigned RCP_M = (64'd1 << KW) / SINE_TABLE_DEPTH;
	localparam int NST      = 12;   // pipeline stages owned by this module
	localparam int ST_PIN   = 6;    // stage feeding the Horner row
	localparam int ST_POUT  = 7;    // stage fed by the Horner row
	localparam logic signed [AB+17:0] HRND = (AB+18)'(longint'(1) << (AB - 1));

	// Handshake: a stage loads when it is empty or its content moves on
	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;
	logic [NST-1:0] prv_vld;
	logic [NST-1:0] nxt_rdy;

	poly_t cb_data [NCELL+1];
	logic  cb_vld  [NCELL+1];
	logic  cb_rdy  [NCELL+1];

	always_comb begin
		prv_vld          = {vld_q[NST-2:0], pose.valid};
		prv_vld[ST_POUT] = cb_vld[NCELL];
		nxt_rdy          = {track.ready, adv[NST-1:1]};
		nxt_rdy[ST_PIN]  = cb_rdy[0];
	end

	assign adv        = ~vld_q | nxt_rdy;
	assign pose.ready = adv[0];
	assign track.valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (adv[i]) begin
					vld_q[i] <= prv_vld[i];
				end
			end
		end
	end

	// Stage 1: table index, position deltas, heading change
	logic [AB-1:0]           h0;
	logic [AB-1:0]           h1;
	logic [AB+IW:0]          iprod;
	logic signed [AB-1:0]    hd;
	logic signed [AB:0]      hn;
	logic signed [AB+17:0]   hnum;
	logic signed [AB+17:0]   hsh;
	side_t                   side_in;

	assign h0    = AB'({{AB{1'b0}}, pose.start_heading});
	assign h1    = AB'({{AB{1'b0}}, pose.end_heading});
	assign iprod = (AB+IW+1)'(h0) * (AB+IW+1)'(SINE_TABLE_DEPTH);
	assign hd    = $signed(h1 - h0);
	assign hn    = -((AB+1)'(hd));
	assign hnum  = (AB+18)'(hn) * (AB+18)'(HEAD_SCALE);
	assign hsh   = (hnum + HRND) >>> AB;

	always_comb begin
		side_in.dx = 33'(pose.end_x) - 33'(pose.start_x);
		side_in.dy = 33'(pose.end_y) - 33'(pose.start_y);
		side_in.hc = 16'(hsh);
	end

	logic [IW-1:0] idx_s1;
	side_t         side_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			idx_s1  <= IW'(iprod >> AB);
			side_s1 <= side_in;
		end
	end

	// Stage 2: phase = idx*Q + floor(idx*R / depth); form both products
	logic [KW-1:0] n_s2;
	logic [31:0]   base_s2;
	side_t         side_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			n_s2    <= KW'(idx_s1) * KW'(PH_R);
			base_s2 <= 32'(idx_s1) * 32'(PH_Q);
			side_s2 <= side_s1;
		end
	end

	// Stage 3: reciprocal estimate of the quotient, at most one short
	logic [2*KW-1:0] qm;
	logic [IW-1:0]   qe_s3;
	logic [KW-1:0]   n_s3;
	logic [31:0]     base_s3;
	side_t           side_s3;

	assign qm = (2*KW)'(n_s2) * (2*KW)'(RCP_M);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			qe_s3   <= IW'(qm >> KW);
			n_s3    <= n_s2;
			base_s3 <= base_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: remainder of the estimate
	logic [IW:0]   r_s4;
	logic [IW-1:0] qe_s4;
	logic [31:0]   base_s4;
	side_t         side_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			r_s4    <= (IW+1)'(n_s3 - KW'(qe_s3) * KW'(SINE_TABLE_DEPTH));
			qe_s4   <= qe_s3;
			base_s4 <= base_s3;
			side_s4 <= side_s3;
		end
	end

	// Stage 5: correct the quotient and close the phase
	logic [31:0] phase_s5;
	side_t       side_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			phase_s5 <= base_s4 + 32'(qe_s4) + 32'(r_s4 >= (IW+1)'(SINE_TABLE_DEPTH));
			side_s5  <= side_s4;
		end
	end

	// Stage 6: fold into the first quadrant; cosine is a quarter turn ahead
	logic [30:0] lo;
	logic [30:0] flo;
	poly_t       fold;
	poly_t       p_s6;

	assign lo  = {1'b0, phase_s5[29:0]};
	assign flo = (31'd1 << 30) - lo;

	always_comb begin
		fold        = '0;
		fold.sn.z   = phase_s5[30] ? flo : lo;
		fold.sn.neg = phase_s5[31];
		fold.cs.z   = phase_s5[30] ? lo : flo;
		fold.cs.neg = phase_s5[31] ^ phase_s5[30];
		fold.side   = side_s5;
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			p_s6 <= fold;
		end
	end

	// Stage 7: square the fraction and seed Horner with the leading term
	poly_t sq;
	poly_t p_s7;

	always_comb begin
		sq       = p_s6;
		sq.sn.z2 = mul_q30(p_s6.sn.z, p_s6.sn.z);
		sq.cs.z2 = mul_q30(p_s6.cs.z, p_s6.cs.z);
		sq.sn.t  = SIN_C9;
		sq.cs.t  = SIN_C9;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_PIN]) begin
			p_s7 <= sq;
		end
	end

	// Row of Horner cells
	assign cb_data[0] = p_s7;
	assign cb_vld[0]  = vld_q[ST_PIN];
	assign cb_rdy[NCELL] = adv[ST_POUT];

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		plhe_horner_cell #(
			.COEF (HORNER_COEF[g])
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cb_vld[g]),
			.up_data  (cb_data[g]),
			.up_ready (cb_rdy[g]),
			.dn_valid (cb_vld[g+1]),
			.dn_data  (cb_data[g+1]),
			.dn_ready (cb_rdy[g+1])
		);
	end

	// Stage 8: close the polynomial, s = z*t
	logic [30:0] ssn_s8;
	logic [30:0] scs_s8;
	logic        nsn_s8;
	logic        ncs_s8;
	side_t       side_s8;

	always_ff @(posedge clk) begin
		if (adv[ST_POUT]) begin
			ssn_s8  <= mul_q30(cb_data[NCELL].sn.z, cb_data[NCELL].sn.t);
			scs_s8  <= mul_q30(cb_data[NCELL].cs.z, cb_data[NCELL].cs.t);
			nsn_s8  <= cb_data[NCELL].sn.neg;
			ncs_s8  <= cb_data[NCELL].cs.neg;
			side_s8 <= cb_data[NCELL].side;
		end
	end

	// Stage 9: round to Q15, cap, sign
	logic signed [15:0] sn_s9;
	logic signed [15:0] cs_s9;
	side_t              side_s9;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			sn_s9   <= q15_of(ssn_s8, nsn_s8);
			cs_s9   <= q15_of(scs_s8, ncs_s8);
			side_s9 <= side_s8;
		end
	end

	// Stage 10: lateral products
	logic signed [48:0] pa_s10;
	logic signed [48:0] pb_s10;
	logic signed [15:0] hc_s10;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			pa_s10 <= 49'(side_s9.dy) * 49'(sn_s9);
			pb_s10 <= 49'(side_s9.dx) * 49'(cs_s9);
			hc_s10 <= side_s9.hc;
		end
	end

	// Stage 11: difference, rounded half up to Q21.10
	logic signed [34:0] w_s11;
	logic signed [15:0] hc_s11;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			w_s11  <= 35'((50'(pa_s10) - 50'(pb_s10) + 50'(Q15_HALF)) >>> 15);
			hc_s11 <= hc_s10;
		end
	end

	// Stage 12: clamp to 32 bits; this is the output register
	logic        ovf;
	logic [31:0] lat_s12;
	logic [15:0] hc_s12;
	logic        sat_s12;

	assign ovf = (w_s11[34:31] != {4{w_s11[34]}});

	always_ff @(posedge clk) begin
		if (adv[NST-1]) begin
			lat_s12 <= ovf ? (w_s11[34] ? LAT_MIN : LAT_MAX) : w_s11[31:0];
			hc_s12  <= hc_s11;
			sat_s12 <= ovf;
		end
	end

	assign track.lateral_offset     = $signed(lat_s12);
	assign track.heading_change_deg = $signed(hc_s12);
	assign track.saturated          = sat_s12;

	// A clamped result sits on one of the two limits
	`PLHE_ASSERT_IMP(a_sat_limit, clk, arst_n, track.valid && track.saturated, track.lateral_offset == $signed(LAT_MAX) || track.lateral_offset == $signed(LAT_MIN), "clamped offset off the limits")
	// Heading change stays within half a turn
	`PLHE_ASSERT_IMP(a_head_range, clk, arst_n, track.valid, track.heading_change_deg >= -16'(HEAD_LIM) && track.heading_change_deg <= 16'(HEAD_LIM), "heading change out of range")
	// A pose transfer always lands in the first stage
	`PLHE_ASSERT_NXT(a_first_load, clk, arst_n, pose.valid && pose.ready, vld_q[0], "pose transfer lost")
	// An item leaving the Horner row and not taken is held
	`PLHE_ASSERT_NXT(a_row_hold, clk, arst_n, cb_vld[NCELL] && !cb_rdy[NCELL], cb_vld[NCELL], "Horner row dropped an item")

endmodule

// ===== hdl/plhe_horner_cell.sv =====
module plhe_horner_cell import plhe_pkg::*; #(
	parameter logic [30:0] COEF = 31'd0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	input  poly_t up_data,
	output logic  up_ready,
	output logic  dn_valid,
	output poly_t dn_data,
	input  logic  dn_ready
);

	logic  adv;
	logic  vld_q;
	poly_t hz_s1;
	poly_t nx;

	assign adv      = !vld_q || dn_ready;
	assign up_ready = adv;
	assign dn_valid = vld_q;
	assign dn_data  = hz_s1;

	// One Horner step on both lanes: t <- C - z2*t
	always_comb begin
		nx      = up_data;
		nx.sn.t = COEF - mul_q30(up_data.sn.z2, up_data.sn.t);
		nx.cs.t = COEF - mul_q30(up_data.cs.z2, up_data.cs.t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hz_s1 <= nx;
		end
	end

endmodule

// ===== test/pose_lateral_and_heading_error_top_tb.sv =====
module pose_lateral_and_heading_error_top_tb;

	localparam int ANGLE_BITS = 16;
	localparam int SINE_DEPTH = 1024;
	localparam int RANDOM_POSES = 1500;
	localparam int TAIL_CYCLES = 32;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] start_x;
		logic [31:0] start_y;
		logic [15:0] start_heading;
		logic [31:0] end_x;
		logic [31:0] end_y;
		logic [15:0] end_heading;
	} pose_t;

	typedef struct packed {
		logic [31:0] lateral_offset;
		logic [15:0] heading_change_deg;
		logic        saturated;
	} track_t;

	// Works out the track error of each accepted pose pair and holds it until
	// the matching transfer leaves the block.
	class track_ledger;
		localparam bit [63:0] Q30_ONE = 64'd1073741824;
		localparam bit [63:0] K1 = 64'd1686629713;
		localparam bit [63:0] K3 = 64'd693598668;
		localparam bit [63:0] K5 = 64'd85569306;
		localparam bit [63:0] K7 = 64'd5026995;
		localparam bit [63:0] K9 = 64'd172272;
		localparam longint LAT_HI = 64'sd2147483647;
		localparam longint LAT_LO = -64'sd2147483648;
		localparam longint HEAD_SCALE = 46080;

		track_t awaited[$];
		int errors;

		// Q1.15 sine of a 32-bit binary angle: fold, Horner in Q30, round.
		function longint sine_q15(bit [31:0] phase);
			bit [63:0] z, z2, t, s;
			z = {34'd0, phase[29:0]};
			if (phase[30])
				z = Q30_ONE - z;
			z2 = (z * z) >> 30;
			t = K9;
			t = K7 - ((z2 * t) >> 30);
			t = K5 - ((z2 * t) >> 30);
			t = K3 - ((z2 * t) >> 30);
			t = K1 - ((z2 * t) >> 30);
			s = (z * t) >> 30;
			s = (s + 64'd16384) >> 15;
			if (s > 64'd32767)
				s = 64'd32767;
			return phase[31] ? -longint'(s) : longint'(s);
		endfunction

		function track_t cross_track_of(pose_t p);
			longint dx, dy, sn, cs, v, lat, d, num, hc;
			bit [63:0] amask, h0, idx, d_u;
			bit [31:0] phase;
			track_t res;
			amask = (64'd1 << ANGLE_BITS) - 64'd1;
			h0 = 64'(p.start_heading) & amask;
			dx = longint'($signed(p.end_x)) - longint'($signed(p.start_x));
			dy = longint'($signed(p.end_y)) - longint'($signed(p.start_y));
			idx = (h0 * SINE_DEPTH) >> ANGLE_BITS;
			phase = 32'((idx << 32) / SINE_DEPTH);
			sn = sine_q15(phase);
			cs = sine_q15(phase + 32'h4000_0000);
			v = dy * sn - dx * cs;
			lat = (v + 64'sd16384) >>> 15;
			res.saturated = 1'b0;
			if (lat > LAT_HI) begin
				lat = LAT_HI;
				res.saturated = 1'b1;
			end else if (lat < LAT_LO) begin
				lat = LAT_LO;
				res.saturated = 1'b1;
			end
			d_u = (64'(p.end_heading) - h0) & amask;
			d = longint'(d_u);
			if (d_u[ANGLE_BITS-1])
				d -= longint'(1) << ANGLE_BITS;
			num = -d * HEAD_SCALE;
			hc = (num + (longint'(1) << (ANGLE_BITS - 1))) >>> ANGLE_BITS;
			res.lateral_offset = lat[31:0];
			res.heading_change_deg = hc[15:0];
			return res;
		endfunction

		function void note_pose(pose_t p);
			awaited.push_back(cross_track_of(p));
		endfunction

		function void check_track(track_t got);
			track_t want;
			if (awaited.size() == 0) begin
				$error("track transfer with no pose awaiting it");
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.lateral_offset !== want.lateral_offset) begin
				$error("lateral_offset: expected %0d, got %0d",
					$signed(want.lateral_offset), $signed(got.lateral_offset));
				errors++;
			end
			if (got.heading_change_deg !== want.heading_change_deg) begin
				$error("heading_change_deg: expected %0d, got %0d",
					$signed(want.heading_change_deg), $signed(got.heading_change_deg));
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	plhe_pose_if  pose();
	plhe_track_if track();

	pose_lateral_and_heading_error_top #(
		.ANGLE_BITS      (ANGLE_BITS),
		.SINE_TABLE_DEPTH(SINE_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pose  (pose),
		.track (track)
	);

	track_ledger ledger;
	bit calm;                  // set for stretches in which neither side idles
	int unsigned cycles;

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Idle cycles before a transfer: none during a calm stretch.
	function automatic int draw_wait();
		return calm ? 0 : int'($urandom_range(0, 16));
	endfunction

	function automatic pose_t mk_pose(logic [31:0] x0, logic [31:0] y0, logic [15:0] h0,
		logic [31:0] x1, logic [31:0] y1, logic [15:0] h1);
		pose_t p;
		p.start_x = x0;
		p.start_y = y0;
		p.start_heading = h0;
		p.end_x = x1;
		p.end_y = y1;
		p.end_heading = h1;
		return p;
	endfunction

	// Offer one pose pair after a random gap and hold it until the block takes
	// it. Valid stays high on return so that back-to-back transfers need no
	// second assignment in the same step.
	task automatic drive_pose(input pose_t p);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			pose.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pose.valid <= 1'b1;
		pose.start_x <= p.start_x;
		pose.start_y <= p.start_y;
		pose.start_heading <= p.start_heading;
		pose.end_x <= p.end_x;
		pose.end_y <= p.end_y;
		pose.end_heading <= p.end_heading;
		do
			@(posedge clk);
		while (!pose.ready);
		ledger.note_pose(p);
	endtask

	// Drop valid and hold the sender until every awaited track has arrived.
	task automatic drain_tracks();
		pose.valid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	// Watchdog: give up far beyond the slowest correct run.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: stall ready for a random number of cycles before each result,
	// then check whatever transfers.
	initial begin
		int stall;
		track_t got;
		track.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				track.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			track.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(track.valid && track.ready));
			got.lateral_offset = track.lateral_offset;
			got.heading_change_deg = track.heading_change_deg;
			got.saturated = track.saturated;
			ledger.check_track(got);
		end
	end

	initial begin
		pose_t directed[$];
		pose_t p;
		int kind;
		int x0, y0, x1, y1;
		logic [15:0] h0, h1;

		ledger = new();
		calm = 1'b0;
		pose.valid = 1'b0;
		pose.start_x = '0;
		pose.start_y = '0;
		pose.start_heading = '0;
		pose.end_x = '0;
		pose.end_y = '0;
		pose.end_heading = '0;

		// Hold reset low, then release it on an edge.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: coincident points at zero and at both range limits.
		directed.push_back(mk_pose(0, 0, 0, 0, 0, 0));
		directed.push_back(mk_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1234,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1234));
		directed.push_back(mk_pose(32'h8000_0000, 32'h8000_0000, 16'hFFFF,
			32'h8000_0000, 32'h8000_0000, 16'hFFFF));
		// Lateral overflow in both directions, through cosine and through sine.
		directed.push_back(mk_pose(32'h8000_0000, 0, 16'h0000, 32'h7FFF_FFFF, 0, 16'h0000));
		directed.push_back(mk_pose(32'h7FFF_FFFF, 0, 16'h0000, 32'h8000_0000, 0, 16'h0000));
		directed.push_back(mk_pose(0, 32'h8000_0000, 16'h4000, 0, 32'h7FFF_FFFF, 16'h4000));
		directed.push_back(mk_pose(0, 32'h7FFF_FFFF, 16'h4000, 0, 32'h8000_0000, 16'h4000));
		directed.push_back(mk_pose(32'h8000_0000, 32'h8000_0000, 16'hE000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000));
		// Opposite headings give exactly plus half a turn.
		directed.push_back(mk_pose(0, 0, 16'h0000, 1024, 1024, 16'h8000));
		directed.push_back(mk_pose(0, 0, 16'h8000, 1024, 1024, 16'h0000));
		directed.push_back(mk_pose(0, 0, 16'h4321, -1024, 2048, 16'hC321));
		// Heading wrap across zero.
		directed.push_back(mk_pose(0, 0, 16'hFFFF, 1024, 0, 16'h0000));
		directed.push_back(mk_pose(0, 0, 16'h0000, 0, 1024, 16'hFFFF));
		directed.push_back(mk_pose(0, 0, 16'h7FFF, 0, 0, 16'h8000));
		// Quadrant boundaries of the start heading.
		for (int q = 0; q < 4; q++) begin
			directed.push_back(mk_pose(0, 0, 16'(q * 16'h4000), 1024, 0, 16'h0000));
			directed.push_back(mk_pose(0, 0, 16'(q * 16'h4000), 0, 1024, 16'h0000));
		end
		directed.push_back(mk_pose(-5000, 7000, 16'h3FFF, 9000, -3000, 16'h0040));
		directed.push_back(mk_pose(1, -1, 16'h003F, -1, 1, 16'hFFC0));

		foreach (directed[i])
			drive_pose(directed[i]);
		drain_tracks();

		// Random: wide spans, nearby pairs, coincident points, edge values and equal or opposite headings.
		for (int n = 0; n < RANDOM_POSES; n++) begin
			if (n % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_POSES / 2)
				drain_tracks();
			kind = $urandom_range(0, 9);
			x0 = $urandom;
			y0 = $urandom;
			h0 = 16'($urandom);
			h1 = 16'($urandom);
			x1 = $urandom;
			y1 = $urandom;
			case (kind)
				4, 5, 6: begin
					x1 = x0 + ($signed($urandom) >>> $urandom_range(1, 31));
					y1 = y0 + ($signed($urandom) >>> $urandom_range(1, 31));
				end
				7: begin
					x1 = x0;
					y1 = y0;
				end
				8: begin
					x0 = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					y0 = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					x1 = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					y1 = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				end
				9: begin
					h1 = $urandom_range(0, 1) ? h0 + 16'h8000 : h0;
				end
				default: ;
			endcase
			p = mk_pose(x0, y0, h0, x1, y1, h1);
			drive_pose(p);
		end

		// Let the pipeline empty, then allow for any stray late transfer.
		drain_tracks();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
